FILE: rtl/pscp_pkg.sv
// ----------------------------------------------------------------------------
// pscp_pkg
// Shared types and codes of the pending spend-conflict pool: result status
// codes, operation codes and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package pscp_pkg;

   localparam int BLK_W    = 64;
   localparam int OUT_W    = 32;
   localparam int REF_BITS = BLK_W + OUT_W;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_CONFLICT = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_TOO_MANY = 2'd3;

   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic       load;          // take the accepted beat
      logic       scan_step;     // read one stored reference
      logic       copy_init;     // point the write address at the free slot
      logic       copy_step;     // write one staged reference
      logic       commit_add;    // mark the slot valid and report ok
      logic       commit_remove; // drop matched slots and report the count
      logic       reject;        // report an add error
      logic [1:0] reject_status;
   } pscp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_end;
      logic copy_end;
      logic last_item;
      logic op_remove;
      logic match;
      logic too_many;
      logic free_found;
   } pscp_stat_type;

endpackage

FILE: rtl/pscp_ctrl.sv
// ----------------------------------------------------------------------------
// pscp_ctrl
// Sequencer of the pool: scans the stored references for each beat, then
// on the last beat of a transaction decides the outcome and, for an add
// that is stored, runs the copy of staged references into the chosen slot.
// ----------------------------------------------------------------------------
module pscp_ctrl
   import pscp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  pscp_stat_type stat,
   output pscp_cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_DRAIN  = 5'b00100,
      S_DECIDE = 5'b01000,
      S_COPY   = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_end) begin
               state_in = S_DRAIN;
            end
         end
         // last read still in the compare stage
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_IDLE;
            if (stat.last_item) begin
               if (stat.op_remove) begin
                  cmd.commit_remove = 1'b1;
               end else if (stat.match) begin
                  cmd.reject        = 1'b1;
                  cmd.reject_status = ST_CONFLICT;
               end else if (stat.too_many) begin
                  cmd.reject        = 1'b1;
                  cmd.reject_status = ST_TOO_MANY;
               end else if (!stat.free_found) begin
                  cmd.reject        = 1'b1;
                  cmd.reject_status = ST_FULL;
               end else begin
                  cmd.copy_init = 1'b1;
                  state_in      = S_COPY;
               end
            end
         end
         S_COPY: begin
            cmd.copy_step = 1'b1;
            if (stat.copy_end) begin
               cmd.commit_add = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

FILE: rtl/pscp_dpath.sv
// ----------------------------------------------------------------------------
// pscp_dpath
// Datapath of the pool: slot reference memory, staging buffer, reference
// compare stage, slot valid bits and the result register.
// ----------------------------------------------------------------------------
module pscp_dpath
   import pscp_pkg::*;
#(
   parameter int SLOTS    = 16,
   parameter int MAX_REFS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  pscp_cmd_type       cmd,
   output pscp_stat_type      stat,
   input  logic               req_operation,
   input  logic [BLK_W-1:0]   req_block_index,
   input  logic [OUT_W-1:0]   req_output_index,
   input  logic               req_last,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [3:0]         rsp_slot,
   output logic [4:0]         rsp_removed_count
);

   localparam int TOTAL  = SLOTS * MAX_REFS;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int REF_W  = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
   localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam int CNT_W  = $clog2(MAX_REFS + 2);

   // storage
   logic [REF_BITS-1:0] mem [TOTAL];
   logic [REF_BITS-1:0] mem_rdata_ff;
   logic [REF_BITS-1:0] staged_ff [MAX_REFS];
   logic [CNT_W-1:0]    ref_count_ff [SLOTS];

   // control state
   logic [SLOTS-1:0]  valid_ff, valid_in;
   logic [SLOTS-1:0]  mask_ff, mask_in;
   logic [CNT_W-1:0]  staged_count_ff, staged_count_in;
   logic              op_ff, op_in;
   logic              match_ff, match_in;
   logic [4:0]        removed_ff, removed_in;
   logic              last_ff, last_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [SLOT_W-1:0] scan_slot_ff, scan_slot_in;
   logic [REF_W-1:0]  scan_ref_ff, scan_ref_in;
   logic              cmp_en_ff, cmp_en_in;
   logic [SLOT_W-1:0] cmp_slot_ff, cmp_slot_in;
   logic [REF_W-1:0]  cmp_ref_ff, cmp_ref_in;
   logic              free_found_ff, free_found_in;
   logic [SLOT_W-1:0] free_slot_ff, free_slot_in;
   logic [CNT_W-1:0]  copy_idx_ff, copy_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [3:0]        rsp_slot_ff, rsp_slot_in;
   logic [4:0]        rsp_removed_ff, rsp_removed_in;

   // payload registers
   logic [REF_BITS-1:0] item_ref_ff;

   logic hit;
   logic first_beat;

   assign first_beat = (staged_count_ff == '0);

   assign hit = cmp_en_ff && valid_ff[cmp_slot_ff]
                && (CNT_W'(cmp_ref_ff) < ref_count_ff[cmp_slot_ff])
                && (mem_rdata_ff == item_ref_ff);

   always_comb begin
      valid_in        = valid_ff;
      mask_in         = mask_ff;
      staged_count_in = staged_count_ff;
      op_in           = op_ff;
      match_in        = match_ff;
      removed_in      = removed_ff;
      last_in         = last_ff;
      addr_in         = addr_ff;
      scan_slot_in    = scan_slot_ff;
      scan_ref_in     = scan_ref_ff;
      cmp_en_in       = cmd.scan_step;
      cmp_slot_in     = scan_slot_ff;
      cmp_ref_in      = scan_ref_ff;
      free_found_in   = free_found_ff;
      free_slot_in    = free_slot_ff;
      copy_idx_in     = copy_idx_ff;
      rsp_valid_in    = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_removed_in  = rsp_removed_ff;

      if (cmd.load) begin
         last_in       = req_last;
         addr_in       = '0;
         scan_slot_in  = '0;
         scan_ref_in   = '0;
         free_found_in = 1'b0;
         if (first_beat) begin
            op_in      = req_operation;
            match_in   = 1'b0;
            mask_in    = '0;
            removed_in = '0;
         end
         if (staged_count_ff <= CNT_W'(MAX_REFS)) begin
            staged_count_in = staged_count_ff + CNT_W'(1);
         end
      end

      if (cmd.scan_step) begin
         if ((scan_ref_ff == '0) && !valid_ff[scan_slot_ff] && !free_found_ff) begin
            free_found_in = 1'b1;
            free_slot_in  = scan_slot_ff;
         end
         addr_in = addr_ff + ADDR_W'(1);
         if (scan_ref_ff == REF_W'(MAX_REFS - 1)) begin
            scan_ref_in  = '0;
            scan_slot_in = scan_slot_ff + SLOT_W'(1);
         end else begin
            scan_ref_in = scan_ref_ff + REF_W'(1);
         end
      end

      // a slot is counted once, the first time one of its references hits
      if (hit) begin
         match_in = 1'b1;
         if (!mask_ff[cmp_slot_ff]) begin
            mask_in[cmp_slot_ff] = 1'b1;
            if (removed_ff != 5'd31) begin
               removed_in = removed_ff + 5'd1;
            end
         end
      end

      if (cmd.copy_init) begin
         addr_in     = ADDR_W'(ADDR_W'(free_slot_ff) * ADDR_W'(MAX_REFS));
         copy_idx_in = '0;
      end

      if (cmd.copy_step) begin
         addr_in     = addr_ff + ADDR_W'(1);
         copy_idx_in = copy_idx_ff + CNT_W'(1);
      end

      if (cmd.commit_add) begin
         valid_in[free_slot_ff] = 1'b1;
         rsp_valid_in    = 1'b1;
         rsp_status_in   = ST_OK;
         rsp_slot_in     = 4'(free_slot_ff);
         rsp_removed_in  = '0;
         staged_count_in = '0;
      end

      if (cmd.commit_remove) begin
         valid_in        = valid_ff & ~mask_ff;
         rsp_valid_in    = 1'b1;
         rsp_status_in   = ST_OK;
         rsp_slot_in     = '0;
         rsp_removed_in  = removed_ff;
         staged_count_in = '0;
      end

      if (cmd.reject) begin
         rsp_valid_in    = 1'b1;
         rsp_status_in   = cmd.reject_status;
         rsp_slot_in     = '0;
         rsp_removed_in  = '0;
         staged_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= '0;
         mask_ff         <= '0;
         staged_count_ff <= '0;
         op_ff           <= OP_ADD;
         match_ff        <= 1'b0;
         removed_ff      <= '0;
         last_ff         <= 1'b0;
         addr_ff         <= '0;
         scan_slot_ff    <= '0;
         scan_ref_ff     <= '0;
         cmp_en_ff       <= 1'b0;
         cmp_slot_ff     <= '0;
         cmp_ref_ff      <= '0;
         free_found_ff   <= 1'b0;
         free_slot_ff    <= '0;
         copy_idx_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
         rsp_status_ff   <= ST_OK;
         rsp_slot_ff     <= '0;
         rsp_removed_ff  <= '0;
      end else begin
         valid_ff        <= valid_in;
         mask_ff         <= mask_in;
         staged_count_ff <= staged_count_in;
         op_ff           <= op_in;
         match_ff        <= match_in;
         removed_ff      <= removed_in;
         last_ff         <= last_in;
         addr_ff         <= addr_in;
         scan_slot_ff    <= scan_slot_in;
         scan_ref_ff     <= scan_ref_in;
         cmp_en_ff       <= cmp_en_in;
         cmp_slot_ff     <= cmp_slot_in;
         cmp_ref_ff      <= cmp_ref_in;
         free_found_ff   <= free_found_in;
         free_slot_ff    <= free_slot_in;
         copy_idx_ff     <= copy_idx_in;
         rsp_valid_ff    <= rsp_valid_in;
         rsp_status_ff   <= rsp_status_in;
         rsp_slot_ff     <= rsp_slot_in;
         rsp_removed_ff  <= rsp_removed_in;
      end
   end

   // beat payload and staging buffer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ref_ff <= {req_block_index, req_output_index};
         if (staged_count_ff < CNT_W'(MAX_REFS)) begin
            staged_ff[staged_count_ff[REF_W-1:0]] <= {req_block_index, req_output_index};
         end
      end
      if (cmd.commit_add) begin
         ref_count_ff[free_slot_ff] <= staged_count_ff;
      end
   end

   // slot reference memory, one write or one read per cycle
   always_ff @(posedge clock) begin
      if (cmd.copy_step) begin
         mem[addr_ff] <= staged_ff[copy_idx_ff[REF_W-1:0]];
      end
      if (cmd.scan_step) begin
         mem_rdata_ff <= mem[addr_ff];
      end
   end

   assign stat.scan_end   = (addr_ff == ADDR_W'(TOTAL - 1));
   assign stat.copy_end   = (copy_idx_ff == staged_count_ff - CNT_W'(1));
   assign stat.last_item  = last_ff;
   assign stat.op_remove  = (op_ff == OP_REMOVE);
   assign stat.match      = match_ff;
   assign stat.too_many   = (staged_count_ff > CNT_W'(MAX_REFS));
   assign stat.free_found = free_found_ff;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_removed_count = rsp_removed_ff;

   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.commit_add, cmd.commit_remove, cmd.reject}))
      else $error("more than one outcome in one cycle");

   a_add_clean: assert property (@(posedge clock) disable iff (reset)
      cmd.commit_add |-> (!match_ff && free_found_ff && !valid_ff[free_slot_ff]
                          && (staged_count_ff <= CNT_W'(MAX_REFS))))
      else $error("add stored despite an error");

   a_mask_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit_remove |-> ((mask_ff & ~valid_ff) == '0))
      else $error("remove mask holds a free slot");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe longer than one cycle");

   a_copy_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.copy_step |-> (copy_idx_ff < CNT_W'(MAX_REFS)))
      else $error("copy past the end of the staging buffer");

endmodule

FILE: rtl/pending_spend_conflict_pool_unit.sv
// ----------------------------------------------------------------------------
// pending_spend_conflict_pool_unit
// Pool of pending transactions with spend-conflict checking on add and
// conflict-based removal.
//
//   channel   handshake           beat contents
//   req       start / busy        operation, block_index, output_index, last
//   rsp       rsp_valid strobe    status, slot, removed_count
//
// For each beat, from accept until busy falls, the pool is scanned:
// every stored reference is read once from the single-port slot memory.
// An add that is stored then copies each staged reference into the slot
// memory; the result strobe follows in the cycle after the copy ends.
// Synchronous reset clears the slot valid bits and staging; no clearing
// pass is needed. The result is shown for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module pending_spend_conflict_pool_unit
   import pscp_pkg::*;
#(
   parameter int SLOTS    = 16,
   parameter int MAX_REFS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic             req_operation,
   input  logic [BLK_W-1:0] req_block_index,
   input  logic [OUT_W-1:0] req_output_index,
   input  logic             req_last,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [3:0]       rsp_slot,
   output logic [4:0]       rsp_removed_count
);

   pscp_cmd_type  cmd;
   pscp_stat_type stat;

   pscp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   pscp_dpath #(
      .SLOTS    (SLOTS),
      .MAX_REFS (MAX_REFS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_operation     (req_operation),
      .req_block_index   (req_block_index),
      .req_output_index  (req_output_index),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_slot          (rsp_slot),
      .rsp_removed_count (rsp_removed_count)
   );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pending spend-conflict pool. Transactions are
// streamed one reference per beat; a scoreboard keeps its own copy of the
// pool, predicts the verdict of each closing beat and checks every result
// strobe against it in order. A directed opening covers the corner cases,
// then random transactions run under three sender idling profiles.
// ----------------------------------------------------------------------------
module tb_top;
   import pscp_pkg::*;

   localparam int SLOTS      = 16;
   localparam int MAX_REFS   = 8;
   localparam int STALL_MAX  = 4000;
   localparam int DRAIN_WAIT = SLOTS * MAX_REFS + MAX_REFS + 24;
   localparam int PHASE_BEATS = 400;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] slot;
      logic [4:0] removed_count;
   } pool_verdict_type;

   class spend_pool_scoreboard;
      bit                 live     [SLOTS];
      bit [BLK_W-1:0]     held_blk [SLOTS][MAX_REFS];
      bit [OUT_W-1:0]     held_out [SLOTS][MAX_REFS];
      int                 held_n   [SLOTS];
      bit [BLK_W-1:0]     open_blk [MAX_REFS];
      bit [OUT_W-1:0]     open_out [MAX_REFS];
      int                 open_n;
      bit                 open_op;
      bit                 open_hit;
      bit [SLOTS-1:0]     open_mask;
      pool_verdict_type   verdicts[$];
      int unsigned        errors;

      function new();
         foreach (live[s]) begin
            live[s]   = 1'b0;
            held_n[s] = 0;
         end
         open_n    = 0;
         open_op   = OP_ADD;
         open_hit  = 1'b0;
         open_mask = '0;
         errors    = 0;
      endfunction

      task report(string msg);
         errors++;
         $display("mismatch: %s", msg);
      endtask

      // fold one accepted beat into the pool copy, queue a verdict on last
      function void note_input(bit op, bit [BLK_W-1:0] blk, bit [OUT_W-1:0] oidx,
                               bit lst);
         pool_verdict_type v;
         int               free_slot;
         int               freed;
         if (open_n == 0) begin
            open_op   = op;
            open_hit  = 1'b0;
            open_mask = '0;
         end
         for (int s = 0; s < SLOTS; s++) begin
            if (live[s]) begin
               for (int r = 0; r < held_n[s] && r < MAX_REFS; r++) begin
                  if (held_blk[s][r] == blk && held_out[s][r] == oidx) begin
                     open_hit     = 1'b1;
                     open_mask[s] = 1'b1;
                  end
               end
            end
         end
         if (open_n < MAX_REFS) begin
            open_blk[open_n] = blk;
            open_out[open_n] = oidx;
         end
         if (open_n <= MAX_REFS)
            open_n++;
         if (!lst)
            return;

         v = '{status: ST_OK, slot: '0, removed_count: '0};
         if (open_op == OP_ADD) begin
            if (open_hit) begin
               v.status = ST_CONFLICT;
            end else if (open_n > MAX_REFS) begin
               v.status = ST_TOO_MANY;
            end else begin
               free_slot = -1;
               for (int s = SLOTS - 1; s >= 0; s--)
                  if (!live[s])
                     free_slot = s;
               if (free_slot < 0) begin
                  v.status = ST_FULL;
               end else begin
                  for (int r = 0; r < open_n; r++) begin
                     held_blk[free_slot][r] = open_blk[r];
                     held_out[free_slot][r] = open_out[r];
                  end
                  held_n[free_slot] = open_n;
                  live[free_slot]   = 1'b1;
                  v.slot            = free_slot[3:0];
               end
            end
         end else begin
            freed = 0;
            for (int s = 0; s < SLOTS; s++) begin
               if (live[s] && open_mask[s]) begin
                  live[s] = 1'b0;
                  if (freed < 31)
                     freed++;
               end
            end
            v.removed_count = freed[4:0];
         end
         open_n    = 0;
         open_hit  = 1'b0;
         open_mask = '0;
         verdicts.push_back(v);
      endfunction

      task check_result(logic [1:0] st, logic [3:0] sl, logic [4:0] rc);
         pool_verdict_type want;
         if (verdicts.size() == 0) begin
            report($sformatf("result beat with none expected (status %0d slot %0d count %0d)",
                             st, sl, rc));
            return;
         end
         want = verdicts.pop_front();
         if (st !== want.status)
            report($sformatf("status got %0d expected %0d", st, want.status));
         if (sl !== want.slot)
            report($sformatf("slot got %0d expected %0d", sl, want.slot));
         if (rc !== want.removed_count)
            report($sformatf("removed_count got %0d expected %0d", rc, want.removed_count));
      endtask

      // a reference currently held in some live slot, if there is one
      function bit pick_held(output bit [BLK_W-1:0] blk, output bit [OUT_W-1:0] oidx);
         int cand[$];
         int s;
         int r;
         blk  = '0;
         oidx = '0;
         for (int i = 0; i < SLOTS; i++)
            if (live[i])
               cand.push_back(i);
         if (cand.size() == 0)
            return 1'b0;
         s    = cand[$urandom_range(cand.size() - 1)];
         r    = $urandom_range(held_n[s] - 1);
         blk  = held_blk[s][r];
         oidx = held_out[s][r];
         return 1'b1;
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic             req_operation;
   logic [BLK_W-1:0] req_block_index;
   logic [OUT_W-1:0] req_output_index;
   logic             req_last;
   logic             rsp_valid;
   logic [1:0]       rsp_status;
   logic [3:0]       rsp_slot;
   logic [4:0]       rsp_removed_count;

   spend_pool_scoreboard sb;
   int                   gap_pct;
   int                   add_pct;
   int                   beats_sent;
   int                   stall_cycles;

   pending_spend_conflict_pool_unit #(
      .SLOTS    (SLOTS),
      .MAX_REFS (MAX_REFS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_block_index   (req_block_index),
      .req_output_index  (req_output_index),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_slot          (rsp_slot),
      .rsp_removed_count (rsp_removed_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(rsp_status, rsp_slot, rsp_removed_count);
   end

   // watchdog: cycles with neither an input nor a result beat
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_beat(bit op, bit [BLK_W-1:0] blk, bit [OUT_W-1:0] oidx, bit lst);
      if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 160)) @(posedge clock);
      end
      start            <= 1'b1;
      req_operation    <= op;
      req_block_index  <= blk;
      req_output_index <= oidx;
      req_last         <= lst;
      do
         @(posedge clock);
      while (busy);
      sb.note_input(op, blk, oidx, lst);
      beats_sent++;
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do
         @(posedge clock);
      while (sb.verdicts.size() != 0);
   endtask

   task automatic fresh_ref(output bit [BLK_W-1:0] blk, output bit [OUT_W-1:0] oidx);
      int roll;
      int flip;
      roll = $urandom_range(99);
      blk  = {$urandom, $urandom};
      oidx = $urandom;
      if (roll < 12 && sb.pick_held(blk, oidx)) begin
         // near miss: one bit away from a held reference
         flip = $urandom_range(BLK_W + OUT_W - 1);
         if (flip < BLK_W)
            blk[flip] = ~blk[flip];
         else
            oidx[flip - BLK_W] = ~oidx[flip - BLK_W];
      end else if (roll < 18) begin
         blk  = BLK_W'($urandom_range(3));
         oidx = $urandom_range(3);
      end else if (roll < 22) begin
         blk  = '1;
         oidx = '1;
      end
   endtask

   task automatic random_txn();
      bit             op;
      bit             dirty;
      int             n;
      int             dirty_at;
      bit [BLK_W-1:0] blk;
      bit [OUT_W-1:0] oidx;
      op = ($urandom_range(99) < add_pct) ? OP_ADD : OP_REMOVE;
      n  = ($urandom_range(99) < 8) ? $urandom_range(MAX_REFS + 1, MAX_REFS + 3)
                                    : $urandom_range(1, MAX_REFS);
      dirty    = (op == OP_REMOVE) ? ($urandom_range(99) < 75) : ($urandom_range(99) < 25);
      dirty_at = $urandom_range(n - 1);
      for (int i = 0; i < n; i++) begin
         if (!(dirty && i == dirty_at && sb.pick_held(blk, oidx)))
            fresh_ref(blk, oidx);
         // operation on later beats is noise
         send_beat((i == 0) ? op : 1'($urandom_range(1)), blk, oidx, i == n - 1);
      end
   endtask

   initial begin
      int txn;
      int target;
      sb               = new();
      reset            <= 1'b1;
      start            <= 1'b0;
      req_operation    <= OP_ADD;
      req_block_index  <= '0;
      req_output_index <= '0;
      req_last         <= 1'b0;
      gap_pct          = 0;
      add_pct          = 85;
      beats_sent       = 0;
      txn              = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed opening
      send_beat(OP_ADD, '0, '0, 1'b1);
      send_beat(OP_ADD, '1, '1, 1'b1);
      send_beat(OP_ADD, '0, '0, 1'b1);
      // over-long add whose only conflict sits past the staging depth
      for (int i = 0; i < MAX_REFS; i++)
         send_beat((i == 0) ? OP_ADD : OP_REMOVE, 64'h100 + i, 32'h200 + i, 1'b0);
      send_beat(OP_REMOVE, '1, '1, 1'b1);
      // duplicate references inside one add
      send_beat(OP_ADD, 64'd5, 32'd5, 1'b0);
      send_beat(OP_ADD, 64'd5, 32'd5, 1'b1);
      send_beat(OP_REMOVE, 64'd7, 32'd7, 1'b1);
      send_beat(OP_REMOVE, '0, '0, 1'b0);
      send_beat(OP_ADD, 64'd5, 32'd5, 1'b1);
      send_beat(OP_REMOVE, '1, '1, 1'b1);
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         gap_pct = (phase == 0) ? 13 : (phase == 1) ? 59 : 0;
         target  = beats_sent + PHASE_BEATS;
         while (beats_sent < target) begin
            if (txn % 40 == 0)
               add_pct = (add_pct == 85) ? 35 : 85;
            random_txn();
            txn++;
            if (txn % 25 == 0)
               wait_drained();
         end
         wait_drained();
      end

      start <= 1'b0;
      while (sb.verdicts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.verdicts.size() != 0)
         sb.report($sformatf("%0d results never arrived", sb.verdicts.size()));
      if (sb.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
